// ----- src/lwcm_pkg.sv -----
// ----------------------------------------------------------------------------
// lwcm_pkg
// Shared types and constants for the layer window and colour math compositor.
// ----------------------------------------------------------------------------
package lwcm_pkg;

  localparam int unsigned PAL_DEPTH   = 256;
  localparam int unsigned PAL_AW      = $clog2(PAL_DEPTH);
  localparam int unsigned COLOR_W     = 15;
  localparam int unsigned COMP_W      = 5;
  localparam int unsigned NUM_COMP    = 3;
  localparam int unsigned WORD_W      = 16;
  localparam int unsigned X_W         = 10;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned MATH_LAYERS = 6;
  localparam int unsigned SCALED_W    = 12;
  localparam int unsigned RECIP_SHIFT = 16;

  localparam logic [WORD_W-1:0] BACKDROP_WORD = 16'h0500;
  localparam logic [7:0]        BOUND_MAX     = 8'd255;
  localparam logic [5:0]        COMP_MAX      = 6'd31;
  // 4370 / 65536 rounds x / 15 down exactly for x up to 255 * 15
  localparam logic [12:0]       RECIP_15      = 13'd4370;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_BOUNDS   = 3'd0,
    REG_WINDOW_SELECT   = 3'd1,
    REG_WINDOW_LOGIC    = 3'd2,
    REG_LAYER_ENABLE    = 3'd3,
    REG_COLOR_MATH_CTRL = 3'd4,
    REG_FIXED_COLOR     = 3'd5,
    REG_DISPLAY_CTRL    = 3'd6,
    REG_MARGIN          = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    WIN_OR   = 2'd0,
    WIN_AND  = 2'd1,
    WIN_XOR  = 2'd2,
    WIN_XNOR = 2'd3
  } win_logic_e;

  typedef enum logic [1:0] {
    MODE_NEVER   = 2'd0,
    MODE_OUTSIDE = 2'd1,
    MODE_INSIDE  = 2'd2,
    MODE_ALWAYS  = 2'd3
  } win_mode_e;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

endpackage

// ----- src/layer_window_colour_math_compositor.sv -----
// ----------------------------------------------------------------------------
// layer_window_colour_math_compositor
// Final pixel stage: layer windows, priority pick for main and sub screen,
// palette lookup, colour math, brightness and force blank.
// ----------------------------------------------------------------------------
//  channel | handshake                | payload
//  in      | in_valid_i / in_ready_o  | cmd, pixel_x, bg0..bg2, sprite, palette
//  out     | out_valid_o / out_ready_i| rgb_o
//  cfg     | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
//  One item per clock while the output is not stalled; a pixel passes the input,
//  palette read, brightness product and output registers before out_valid_o rises.
//  A palette write takes effect when it leaves the input register and gives
//  no result; a following pixel sees the new entry.
//  Each stage holds while the next is full and stalled; in_ready_o drops only
//  when every stage is full and the output waits.
//  Reset returns the registers to their defaults (force blank set) and clears
//  the stage valid flags; the palette is not cleared.
// ----------------------------------------------------------------------------
module layer_window_colour_math_compositor
  import lwcm_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        cmd_i,
  input  logic signed [X_W-1:0]       pixel_x_i,
  input  logic [WORD_W-1:0]           bg0_word_i,
  input  logic [WORD_W-1:0]           bg1_word_i,
  input  logic [WORD_W-1:0]           bg2_word_i,
  input  logic [WORD_W-1:0]           sprite_word_i,
  input  logic [PAL_AW-1:0]           palette_index_i,
  input  logic [COLOR_W-1:0]          palette_color_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [23:0]                 rgb_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [CFG_DATA_W-1:0]       cfg_data_i
);

  logic [31:0] win_bounds_q;
  logic [23:0] win_select_q;
  logic [11:0] win_logic_q;
  logic [19:0] layer_en_q;
  logic [15:0] cm_ctrl_q;
  logic [COLOR_W-1:0] fixed_q;
  logic [7:0]  disp_q;
  logic [7:0]  margin_q;

  logic s1_v_q, s2_v_q, s3_v_q, out_v_q;
  logic adv1, adv2, adv3, adv_out;

  logic                  s1_cmd_q;
  logic signed [X_W-1:0] s1_x_q;
  logic [WORD_W-1:0]     s1_w0_q, s1_w1_q, s1_w2_q, s1_w4_q;
  logic [PAL_AW-1:0]     s1_idx_q;
  logic [COLOR_W-1:0]    s1_col_q;

  logic [COLOR_W-1:0] pal_mem [PAL_DEPTH];
  logic [COLOR_W-1:0] main_rd_q, sub_rd_q;
  logic [3:0]         s2_lay_q;
  logic               s2_sub_nz_q, s2_inside_q;

  logic [NUM_COMP-1:0][SCALED_W-1:0] s3_scaled_q, s3_scaled_d;
  logic [23:0] rgb_q, rgb_d;

  logic [4:0]        hits;
  logic              cm_win;
  logic [WORD_W-1:0] main_w, sub_w;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_bounds_q <= '0;
      win_select_q <= '0;
      win_logic_q  <= '0;
      layer_en_q   <= '0;
      cm_ctrl_q    <= '0;
      fixed_q      <= '0;
      disp_q       <= 8'd128;
      margin_q     <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_WINDOW_BOUNDS:   win_bounds_q <= cfg_data_i;
        REG_WINDOW_SELECT:   win_select_q <= cfg_data_i[23:0];
        REG_WINDOW_LOGIC:    win_logic_q  <= cfg_data_i[11:0];
        REG_LAYER_ENABLE:    layer_en_q   <= cfg_data_i[19:0];
        REG_COLOR_MATH_CTRL: cm_ctrl_q    <= cfg_data_i[15:0];
        REG_FIXED_COLOR:     fixed_q      <= cfg_data_i[COLOR_W-1:0];
        REG_DISPLAY_CTRL:    disp_q       <= cfg_data_i[7:0];
        REG_MARGIN:          margin_q     <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign adv_out    = !out_v_q || out_ready_i;
  assign adv3       = !s3_v_q || adv_out;
  assign adv2       = !s2_v_q || adv3;
  assign adv1       = !s1_v_q || adv2;
  assign in_ready_o = adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (adv1)    s1_v_q  <= in_valid_i;
      if (adv2)    s2_v_q  <= s1_v_q && (s1_cmd_q == CMD_PIXEL);
      if (adv3)    s3_v_q  <= s2_v_q;
      if (adv_out) out_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) begin
      s1_cmd_q <= cmd_i;
      s1_x_q   <= pixel_x_i;
      s1_w0_q  <= bg0_word_i;
      s1_w1_q  <= bg1_word_i;
      s1_w2_q  <= bg2_word_i;
      s1_w4_q  <= sprite_word_i;
      s1_idx_q <= palette_index_i;
      s1_col_q <= palette_color_i;
    end
  end

  // ---------------- stage 1: windows and priority pick ----------------

  function automatic logic [10:0] left_bound(input logic [7:0] b, input logic [7:0] m);
    logic [10:0] r;
    if (b == 8'd0) r = 11'd0 - {3'b000, m};
    else           r = {3'b000, b};
    return r;
  endfunction

  function automatic logic [10:0] right_bound(input logic [7:0] b, input logic [7:0] m);
    logic [10:0] r;
    if (b == BOUND_MAX) r = {3'b000, BOUND_MAX} + {3'b000, m};
    else                r = {3'b000, b};
    return r;
  endfunction

  function automatic logic win_hit(input logic [3:0] flags, input logic [1:0] lsel,
                                   input logic in1, input logic in2);
    logic a, b, r;
    a = in1 ^ flags[0];
    b = in2 ^ flags[2];
    if (!flags[1]) begin
      r = flags[3] && b;
    end else if (!flags[3]) begin
      r = a;
    end else begin
      case (win_logic_e'(lsel))
        WIN_OR:   r = a || b;
        WIN_AND:  r = a && b;
        WIN_XOR:  r = a ^ b;
        WIN_XNOR: r = !(a ^ b);
        default:  r = 1'b0;
      endcase
    end
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] pick(input logic [4:0] en, input logic [4:0] wd,
                                             input logic [4:0] hit,
                                             input logic [WORD_W-1:0] w0,
                                             input logic [WORD_W-1:0] w1,
                                             input logic [WORD_W-1:0] w2,
                                             input logic [WORD_W-1:0] w4);
    logic [WORD_W-1:0] best;
    best = BACKDROP_WORD;
    if (en[0] && !(wd[0] && hit[0]) && w0 > best) best = w0;
    if (en[1] && !(wd[1] && hit[1]) && w1 > best) best = w1;
    if (en[2] && !(wd[2] && hit[2]) && w2 > best) best = w2;
    if (en[4] && !(wd[4] && hit[4]) && w4 > best) best = w4;
    return best;
  endfunction

  always_comb begin
    logic signed [10:0] x, b1l, b1r, b2l, b2r;
    logic in1, in2;
    x   = {s1_x_q[X_W-1], s1_x_q};
    b1l = left_bound(win_bounds_q[7:0], margin_q);
    b1r = right_bound(win_bounds_q[15:8], margin_q);
    b2l = left_bound(win_bounds_q[23:16], margin_q);
    b2r = right_bound(win_bounds_q[31:24], margin_q);
    in1 = (x >= b1l) && (x <= b1r);
    in2 = (x >= b2l) && (x <= b2r);
    hits[0] = win_hit(win_select_q[3:0],   win_logic_q[1:0],  in1, in2);
    hits[1] = win_hit(win_select_q[7:4],   win_logic_q[3:2],  in1, in2);
    hits[2] = win_hit(win_select_q[11:8],  win_logic_q[5:4],  in1, in2);
    hits[3] = 1'b0;
    hits[4] = win_hit(win_select_q[19:16], win_logic_q[9:8],  in1, in2);
    cm_win  = win_hit(win_select_q[23:20], win_logic_q[11:10], in1, in2);
    main_w  = pick(layer_en_q[4:0], layer_en_q[14:10], hits,
                   s1_w0_q, s1_w1_q, s1_w2_q, s1_w4_q);
    sub_w   = pick(layer_en_q[9:5], layer_en_q[19:15], hits,
                   s1_w0_q, s1_w1_q, s1_w2_q, s1_w4_q);
  end

  always_ff @(posedge clk_i) begin
    if (s1_v_q && adv2) begin
      if (s1_cmd_q == CMD_WRITE) begin
        pal_mem[s1_idx_q] <= s1_col_q;
      end else begin
        main_rd_q <= pal_mem[main_w[PAL_AW-1:0]];
        sub_rd_q  <= pal_mem[sub_w[PAL_AW-1:0]];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_v_q && adv2 && (s1_cmd_q == CMD_PIXEL)) begin
      s2_lay_q    <= main_w[11:8];
      s2_sub_nz_q <= (sub_w[PAL_AW-1:0] != '0);
      s2_inside_q <= cm_win;
    end
  end

  // ---------------- stage 2: colour math and brightness ----------------

  function automatic logic mode_met(input logic [1:0] mode, input logic ins);
    logic r;
    case (win_mode_e'(mode))
      MODE_NEVER:   r = 1'b0;
      MODE_OUTSIDE: r = !ins;
      MODE_INSIDE:  r = ins;
      MODE_ALWAYS:  r = 1'b1;
      default:      r = 1'b0;
    endcase
    return r;
  endfunction

  always_comb begin
    logic clipped, math, half, lay_ok;
    logic [COLOR_W-1:0] other;
    logic [COMP_W-1:0]  c0, sec, cf;
    logic signed [6:0]  sum;
    logic [5:0]         pos;
    logic [7:0]         c8;
    lay_ok  = (s2_lay_q < 4'(MATH_LAYERS)) && cm_ctrl_q[8 + s2_lay_q[2:0]];
    clipped = mode_met(cm_ctrl_q[7:6], s2_inside_q);
    math    = !mode_met(cm_ctrl_q[5:4], s2_inside_q) && lay_ok;
    half    = math && cm_ctrl_q[14] && !clipped;
    other   = fixed_q;
    if (math && cm_ctrl_q[1]) begin
      if (s2_sub_nz_q) other = sub_rd_q;
      else             half  = 1'b0;
    end
    for (int k = 0; k < NUM_COMP; k++) begin
      c0  = clipped ? '0 : main_rd_q[k*COMP_W +: COMP_W];
      sec = other[k*COMP_W +: COMP_W];
      if (cm_ctrl_q[15]) sum = $signed({2'b00, c0}) - $signed({2'b00, sec});
      else               sum = $signed({2'b00, c0}) + $signed({2'b00, sec});
      pos = sum[6] ? 6'd0 : sum[5:0];
      if (half) pos = pos >> 1;
      cf  = (pos > COMP_MAX) ? COMP_MAX[COMP_W-1:0] : pos[COMP_W-1:0];
      if (!math) cf = c0;
      c8  = {cf, cf[4:2]};
      if (disp_q[7]) s3_scaled_d[k] = '0;
      else           s3_scaled_d[k] = SCALED_W'(c8) * SCALED_W'(disp_q[3:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_v_q && adv3) s3_scaled_q <= s3_scaled_d;
  end

  // ---------------- stage 3: divide by 15 ----------------

  always_comb begin
    logic [24:0] prod;
    rgb_d = '0;
    for (int k = 0; k < NUM_COMP; k++) begin
      prod = 25'(s3_scaled_q[k]) * 25'(RECIP_15);
      rgb_d[16 - k*8 +: 8] = prod[RECIP_SHIFT +: 8];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_v_q && adv_out) rgb_q <= rgb_d;
  end

  assign out_valid_o = out_v_q;
  assign rgb_o       = rgb_q;

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_v_q |-> in_ready_o)
    else $error("input stalled with an empty output register");

  a_write_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q && (s1_cmd_q == CMD_WRITE) && adv2 |=> !s2_v_q)
    else $error("palette write item entered the pixel path");

  a_stage3_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_v_q && !adv3 |=> s3_v_q && $stable(s3_scaled_q))
    else $error("stalled item lost in product stage");

  a_out_from_stage3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_v_q && !s3_v_q |=> !out_v_q)
    else $error("result appeared without an item in flight");

endmodule

// ----- test/compositor_checker.sv -----
// ----------------------------------------------------------------------------
// compositor_checker
// Watches the input, configuration and output channels of the compositor,
// keeps its own copy of the registers and the palette, predicts the rgb of
// every accepted pixel item and compares each result with the oldest
// prediction.
// ----------------------------------------------------------------------------
module compositor_checker
  import lwcm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic                  cmd_i,
  input  logic signed [X_W-1:0] pixel_x_i,
  input  logic [WORD_W-1:0]     bg0_word_i,
  input  logic [WORD_W-1:0]     bg1_word_i,
  input  logic [WORD_W-1:0]     bg2_word_i,
  input  logic [WORD_W-1:0]     sprite_word_i,
  input  logic [PAL_AW-1:0]     palette_index_i,
  input  logic [COLOR_W-1:0]    palette_color_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [23:0]           rgb_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  drain_i,
  output int                    pending_o,
  output int                    fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0]        bounds_q;
  logic [23:0]        select_q;
  logic [11:0]        win_ops_q;
  logic [19:0]        enable_q;
  logic [15:0]        math_ctrl_q;
  logic [COLOR_W-1:0] fixed_q;
  logic [7:0]         disp_q;
  logic [7:0]         margin_q;
  logic [COLOR_W-1:0] palette_q [PAL_DEPTH];
  logic [23:0]        expected_rgb_q [$];
  int                 fail_count = 0;
  int                 pending = 0;
  bit                 leftover_seen = 1'b0;

  assign pending_o    = pending;
  assign fail_count_o = fail_count;

  task automatic report_fault(string msg);
    $display("%0t ns error: %s", $time, msg);
    fail_count++;
  endtask

  function automatic bit window_hit(int unsigned lay, int x);
    logic [3:0] flags;
    int         l1, r1, l2, r2;
    bit         a, b;
    flags = select_q[lay*4 +: 4];
    l1 = int'(bounds_q[7:0]);
    r1 = int'(bounds_q[15:8]);
    l2 = int'(bounds_q[23:16]);
    r2 = int'(bounds_q[31:24]);
    if (l1 == 0) l1 = -int'(margin_q);
    if (r1 == int'(BOUND_MAX)) r1 = int'(BOUND_MAX) + int'(margin_q);
    if (l2 == 0) l2 = -int'(margin_q);
    if (r2 == int'(BOUND_MAX)) r2 = int'(BOUND_MAX) + int'(margin_q);
    a = (x >= l1 && x <= r1) ^ flags[0];
    b = (x >= l2 && x <= r2) ^ flags[2];
    if (!flags[1]) return flags[3] && b;
    if (!flags[3]) return a;
    case (win_logic_e'(win_ops_q[lay*2 +: 2]))
      WIN_OR:  return a || b;
      WIN_AND: return a && b;
      WIN_XOR: return a != b;
      default: return a == b;
    endcase
  endfunction

  function automatic bit mode_met(win_mode_e mode, bit in_win);
    return mode == MODE_ALWAYS || (mode == MODE_OUTSIDE && !in_win) ||
           (mode == MODE_INSIDE && in_win);
  endfunction

  function automatic logic [23:0] blend_color(logic [WORD_W-1:0] main_w,
                                              logic [WORD_W-1:0] sub_w, bit in_win);
    logic [7:0]         sel, add;
    logic [COLOR_W-1:0] base, other;
    logic [3:0]         lay;
    bit                 clipped, math, half;
    int                 c, second;
    logic [31:0]        v;
    logic [23:0]        result;
    sel     = math_ctrl_q[7:0];
    add     = math_ctrl_q[15:8];
    base    = palette_q[main_w[7:0]];
    lay     = main_w[11:8];
    clipped = mode_met(win_mode_e'(sel[7:6]), in_win);
    math    = !mode_met(win_mode_e'(sel[5:4]), in_win) &&
              ((lay < MATH_LAYERS) ? add[lay] : 1'b0);
    other   = fixed_q;
    half    = math && add[6] && !clipped;
    result  = '0;
    if (math && sel[1]) begin
      if (sub_w[7:0] != 0) other = palette_q[sub_w[7:0]];
      else half = 1'b0;
    end
    for (int k = 0; k < NUM_COMP; k++) begin
      c = clipped ? 0 : int'(base[k*COMP_W +: COMP_W]);
      if (math) begin
        second = int'(other[k*COMP_W +: COMP_W]);
        c = add[7] ? c - second : c + second;
        if (c < 0) c = 0;
        if (half) c = c / 2;
        if (c > int'(COMP_MAX)) c = int'(COMP_MAX);
      end
      v = (((c << 3) | (c >> 2)) * int'(disp_q[3:0])) / 15;
      result[16 - k*8 +: 8] = v[7:0];
    end
    return result;
  endfunction

  function automatic logic [23:0] composite_pixel(logic signed [X_W-1:0] x_raw,
                                                  logic [WORD_W-1:0] w0,
                                                  logic [WORD_W-1:0] w1,
                                                  logic [WORD_W-1:0] w2,
                                                  logic [WORD_W-1:0] ws);
    logic [WORD_W-1:0] words [5];
    logic [WORD_W-1:0] screens [2];
    logic [4:0]        en, wd;
    int                x;
    if (disp_q[7]) return '0;
    x = int'(x_raw);
    words[0] = w0;
    words[1] = w1;
    words[2] = w2;
    words[3] = '0;
    words[4] = ws;
    for (int s = 0; s < 2; s++) begin
      en = enable_q[s*5 +: 5];
      wd = enable_q[10 + s*5 +: 5];
      screens[s] = BACKDROP_WORD;
      for (int lay = 0; lay < 5; lay++) begin
        if (lay == 3 || !en[lay]) continue;
        if (wd[lay] && window_hit(lay, x)) continue;
        if (words[lay] > screens[s]) screens[s] = words[lay];
      end
    end
    return blend_color(screens[0], screens[1], window_hit(5, x));
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [23:0] want;
    if (!rst_ni) begin
      bounds_q    = '0;
      select_q    = '0;
      win_ops_q   = '0;
      enable_q    = '0;
      math_ctrl_q = '0;
      fixed_q     = '0;
      disp_q      = 8'd128;
      margin_q    = '0;
      expected_rgb_q.delete();
      pending     = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_rgb_q.size() == 0) begin
          report_fault($sformatf("unexpected result rgb %06h", rgb_i));
        end else begin
          want = expected_rgb_q.pop_front();
          if (rgb_i !== want) begin
            report_fault($sformatf("rgb %06h, predicted %06h", rgb_i, want));
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_WINDOW_BOUNDS:   bounds_q    = cfg_data_i;
          REG_WINDOW_SELECT:   select_q    = cfg_data_i[23:0];
          REG_WINDOW_LOGIC:    win_ops_q   = cfg_data_i[11:0];
          REG_LAYER_ENABLE:    enable_q    = cfg_data_i[19:0];
          REG_COLOR_MATH_CTRL: math_ctrl_q = cfg_data_i[15:0];
          REG_FIXED_COLOR:     fixed_q     = cfg_data_i[COLOR_W-1:0];
          REG_DISPLAY_CTRL:    disp_q      = cfg_data_i[7:0];
          REG_MARGIN:          margin_q    = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        if (cmd_i == CMD_WRITE) begin
          palette_q[palette_index_i] = palette_color_i;
        end else begin
          expected_rgb_q.push_back(composite_pixel(pixel_x_i, bg0_word_i, bg1_word_i,
                                                   bg2_word_i, sprite_word_i));
        end
      end
      if (drain_i && expected_rgb_q.size() != 0 && !leftover_seen) begin
        leftover_seen = 1'b1;
        report_fault($sformatf("%0d predicted results never came",
                               expected_rgb_q.size()));
      end
      pending = expected_rgb_q.size();
    end
  end

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives the compositor with palette writes and pixel items under bursty
// input and a stalling output, steps through many register settings while
// the block is idle, and reports the verdict from the checker's count.
// ----------------------------------------------------------------------------
module testbench;
  import lwcm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT     = 4000;
  localparam int RESULT_LATENCY  = 8;
  localparam int PHASES          = 16;
  localparam int ITEMS_PER_PHASE = 55;

  typedef enum int {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PERIODIC,
    STALL_BURSTY
  } stall_mode_e;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  cmd;
  logic signed [X_W-1:0] pixel_x;
  logic [WORD_W-1:0]     bg0_word;
  logic [WORD_W-1:0]     bg1_word;
  logic [WORD_W-1:0]     bg2_word;
  logic [WORD_W-1:0]     sprite_word;
  logic [PAL_AW-1:0]     palette_index;
  logic [COLOR_W-1:0]    palette_color;
  logic                  out_valid;
  logic                  out_ready;
  logic [23:0]           rgb;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  drain;
  int                    pending;
  int                    fail_count;

  bit                    written_map [PAL_DEPTH];
  int unsigned           written_list [$];
  int                    pixel_count = 0;
  int                    write_count = 0;
  int                    setting_count = 0;
  int                    idle_cycles = 0;

  layer_window_colour_math_compositor dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .cmd_i          (cmd),
    .pixel_x_i      (pixel_x),
    .bg0_word_i     (bg0_word),
    .bg1_word_i     (bg1_word),
    .bg2_word_i     (bg2_word),
    .sprite_word_i  (sprite_word),
    .palette_index_i(palette_index),
    .palette_color_i(palette_color),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .rgb_o          (rgb),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  compositor_checker chk (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .cmd_i          (cmd),
    .pixel_x_i      (pixel_x),
    .bg0_word_i     (bg0_word),
    .bg1_word_i     (bg1_word),
    .bg2_word_i     (bg2_word),
    .sprite_word_i  (sprite_word),
    .palette_index_i(palette_index),
    .palette_color_i(palette_color),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .rgb_i          (rgb),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .drain_i        (drain),
    .pending_o      (pending),
    .fail_count_o   (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : receiver
    stall_mode_e mode;
    int          span;
    int          low_left;
    out_ready = 1'b0;
    low_left  = 0;
    forever begin
      mode = stall_mode_e'($urandom_range(3));
      span = $urandom_range(16, 80);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          STALL_NONE:     out_ready = 1'b1;
          STALL_RANDOM:   out_ready = 1'($urandom_range(1));
          STALL_PERIODIC: out_ready = ($urandom_range(3) != 0);
          default: begin
            if (low_left > 0) begin
              out_ready = 1'b0;
              low_left--;
            end else if ($urandom_range(5) == 0) begin
              out_ready = 1'b0;
              low_left  = $urandom_range(11);
            end else begin
              out_ready = 1'b1;
            end
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("stalled for %0d cycles with %0d results outstanding", idle_cycles, pending);
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [PAL_AW-1:0] pick_index();
    return PAL_AW'(written_list[$urandom_range(written_list.size() - 1)]);
  endfunction

  function automatic logic [WORD_W-1:0] any_word();
    logic [3:0] lay;
    int         pick;
    pick = $urandom_range(7);
    if (pick == 0) return '0;
    if (pick == 1) lay = 4'($urandom_range(15));
    else lay = 4'($urandom_range(5));
    return {4'($urandom_range(15)), lay, pick_index()};
  endfunction

  function automatic logic signed [X_W-1:0] any_x();
    if ($urandom_range(3) == 0) return X_W'($urandom_range(255));
    return X_W'($urandom);
  endfunction

  function automatic logic [7:0] bound_byte();
    case ($urandom_range(3))
      0:       return 8'd0;
      1:       return BOUND_MAX;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic drive_item(logic c, logic signed [X_W-1:0] x, logic [WORD_W-1:0] w0,
                            logic [WORD_W-1:0] w1, logic [WORD_W-1:0] w2,
                            logic [WORD_W-1:0] ws, logic [PAL_AW-1:0] idx,
                            logic [COLOR_W-1:0] col);
    @(negedge clk);
    in_valid      = 1'b1;
    cmd           = c;
    pixel_x       = x;
    bg0_word      = w0;
    bg1_word      = w1;
    bg2_word      = w2;
    sprite_word   = ws;
    palette_index = idx;
    palette_color = col;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_pixel(logic signed [X_W-1:0] x, logic [WORD_W-1:0] w0,
                            logic [WORD_W-1:0] w1, logic [WORD_W-1:0] w2,
                            logic [WORD_W-1:0] ws);
    drive_item(CMD_PIXEL, x, w0, w1, w2, ws, PAL_AW'($urandom), COLOR_W'($urandom));
    pixel_count++;
  endtask

  task automatic send_write(logic [PAL_AW-1:0] idx, logic [COLOR_W-1:0] col);
    if (!written_map[idx]) begin
      written_map[idx] = 1'b1;
      written_list.push_back(idx);
    end
    drive_item(CMD_WRITE, X_W'($urandom), any_word(), any_word(), any_word(), any_word(),
               idx, col);
    write_count++;
  endtask

  task automatic rest_input(int n);
    if (n > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (RESULT_LATENCY) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_e r, logic [CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = r;
    cfg_data  = d;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic configure(logic [31:0] win_bounds, logic [23:0] win_select,
                           logic [11:0] win_ops, logic [19:0] layer_en,
                           logic [15:0] math_ctrl, logic [14:0] fixed_col,
                           logic [7:0] disp_ctrl, logic [7:0] margin_px);
    settle();
    write_reg(REG_WINDOW_BOUNDS, win_bounds);
    write_reg(REG_WINDOW_SELECT, 32'(win_select));
    write_reg(REG_WINDOW_LOGIC, 32'(win_ops));
    write_reg(REG_LAYER_ENABLE, 32'(layer_en));
    write_reg(REG_COLOR_MATH_CTRL, 32'(math_ctrl));
    write_reg(REG_FIXED_COLOR, 32'(fixed_col));
    write_reg(REG_DISPLAY_CTRL, 32'(disp_ctrl));
    write_reg(REG_MARGIN, 32'(margin_px));
    setting_count++;
  endtask

  task automatic random_settings();
    logic [19:0] layer_en;
    logic [7:0]  disp_ctrl;
    logic [7:0]  margin_px;
    layer_en = 20'($urandom);
    if ($urandom_range(1) == 0) layer_en[9:0] = 10'h3FF;
    disp_ctrl = 8'($urandom);
    disp_ctrl[7] = ($urandom_range(9) == 0);
    if ($urandom_range(1) == 0) disp_ctrl[3:0] = 4'hF;
    case ($urandom_range(2))
      0:       margin_px = 8'd0;
      1:       margin_px = 8'd255;
      default: margin_px = 8'($urandom);
    endcase
    configure({bound_byte(), bound_byte(), bound_byte(), bound_byte()}, 24'($urandom),
              12'($urandom), layer_en, 16'($urandom), 15'($urandom), disp_ctrl,
              margin_px);
  endtask

  initial begin : stimulus
    int  burst_left;
    bit  steady;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    cmd           = CMD_PIXEL;
    pixel_x       = '0;
    bg0_word      = '0;
    bg1_word      = '0;
    bg2_word      = '0;
    sprite_word   = '0;
    palette_index = '0;
    palette_color = '0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_WINDOW_BOUNDS;
    cfg_data      = '0;
    drain         = 1'b0;
    burst_left    = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_write(8'd0, 15'h0000);
    send_write(8'd255, 15'h7FFF);
    send_write(8'd1, 15'h7C1F);
    send_write(8'd2, 15'h03E0);
    send_pixel(10'sd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);

    configure(32'h0, 24'h0, 12'h0, 20'h003FF, 16'h0000, 15'h0, 8'h0F, 8'h0);
    send_pixel(-10'sd512, 16'hF0FF, 16'h1001, 16'h0000, 16'h2402);
    send_pixel(10'sd511, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
    send_pixel(10'sd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);

    // sub screen operand with halving; transparent sub falls back to fixed
    configure(32'h0, 24'h0, 12'h0, 20'h00041, 16'h7F02, 15'h4210, 8'h0F, 8'h0);
    send_pixel(10'sd100, 16'h1001, 16'h1100, 16'h0000, 16'h0000);
    send_pixel(10'sd100, 16'h1001, 16'h11FF, 16'h0000, 16'h0000);
    send_pixel(10'sd100, 16'h1801, 16'h11FF, 16'h0000, 16'h0000);

    configure(32'h0, 24'h0, 12'h0, 20'h00041, 16'hBF02, 15'h7FFF, 8'h0F, 8'h0);
    send_pixel(10'sd5, 16'h10FF, 16'h11FF, 16'h0000, 16'h0000);
    send_pixel(10'sd5, 16'h1002, 16'h11FF, 16'h0000, 16'h0000);

    // full-width windows stretched into wide margins, one-window layers
    configure(32'hFF00FF00, 24'hE00082, 12'h800, 20'h00C03, 16'h3F80, 15'h1234, 8'h0F,
              8'hFF);
    send_pixel(-10'sd255, 16'h1001, 16'h2102, 16'h0000, 16'h0000);
    send_pixel(-10'sd256, 16'h1001, 16'h2102, 16'h0000, 16'h0000);
    send_pixel(10'sd510, 16'h1001, 16'h2102, 16'h0000, 16'h0000);
    send_pixel(10'sd511, 16'h1001, 16'h2102, 16'h0000, 16'h0000);
    send_pixel(10'sd128, 16'h1001, 16'h2102, 16'h0000, 16'h0000);

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: configure(32'hFFFFFFFF, 24'hFFFFFF, 12'hFFF, 20'hFFFFF, 16'hFFFF, 15'h7FFF,
                     8'h0F, 8'hFF);
        1: configure(32'h0, 24'h0, 12'h0, 20'h0, 16'h0, 15'h0, 8'h0F, 8'h0);
        2: configure(32'hFFFFFFFF, 24'hFFFFFF, 12'hFFF, 20'hFFFFF, 16'hFFFF, 15'h7FFF,
                     8'hFF, 8'hFF);
        default: random_settings();
      endcase
      steady = (phase % 4 == 1);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          if (!steady) rest_input($urandom_range(5));
        end
        burst_left--;
        if (n == ITEMS_PER_PHASE / 2 && phase % 3 == 0) settle();
        if ($urandom_range(99) < 15) begin
          send_write(PAL_AW'($urandom), COLOR_W'($urandom));
        end else begin
          send_pixel(any_x(), any_word(), any_word(), any_word(), any_word());
        end
      end
    end

    settle();
    drain = 1'b1;
    repeat (2) @(negedge clk);
    $display("covered %0d pixel items and %0d palette writes over %0d register settings",
             pixel_count, write_count, setting_count);
    $display("palette entries written: %0d of %0d", written_list.size(), PAL_DEPTH);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- layer_window_colour_math_compositor.f -----
src/lwcm_pkg.sv
src/layer_window_colour_math_compositor.sv
test/compositor_checker.sv
test/testbench.sv
